@@ rtl/wfba_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package wfba_pkg;

    // Fixed field widths
    localparam int AMOUNT_BITS  = 16;
    localparam int ADDR_BITS    = 24;
    localparam int OWNER_BITS   = 16;
    localparam int IDX_OUT_BITS = 5;

    // Defaults for the top-level parameters
    localparam int MAX_ENTRIES_DEF = 32;
    localparam int SIZE_BITS_DEF   = 16;

    // Result status codes
    typedef enum logic [1:0] {
        ST_DONE  = 2'd0,
        ST_NOFIT = 2'd1,
        ST_FULL  = 2'd2
    } t_status;

    // Sequencer states
    typedef enum logic [2:0] {
        S_IDLE,
        S_LOAD,
        S_SCAN,
        S_DECIDE,
        S_SHIFT,
        S_WR_REM,
        S_WR_BEST,
        S_FINISH
    } t_state;

endpackage

`default_nettype wire

@@ rtl/wfba_mem.sv @@
`timescale 1ns / 1ps
`default_nettype none

module wfba_mem #(
    parameter int DEPTH = 32,
    parameter int AW    = 5,
    parameter int DW    = 57
) (
    input  wire logic          i_clk,
    input  wire logic          i_we,
    input  wire logic [AW-1:0] i_waddr,
    input  wire logic [DW-1:0] i_wdata,
    input  wire logic          i_re,
    input  wire logic [AW-1:0] i_raddr,
    output logic      [DW-1:0] o_rdata
);

    logic [DW-1:0] r_mem [DEPTH];
    logic [DW-1:0] r_rdata;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read port
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

@@ rtl/worst_fit_block_allocator.sv @@
// Load: passes through the load and finish states to the output register, with at
// most one table write. Allocation: scans every entry, then on a split moves later
// entries up before the remainder write; paced by the single memory port pair.
// One request in flight; a new request is taken while a finished result waits.
// Synchronous active-low reset clears control state and counters only; the entry
// table has no clearing pass and entries at or above the count are never read.
`timescale 1ns / 1ps
`default_nettype none

module worst_fit_block_allocator #(
    parameter int MAX_ENTRIES = wfba_pkg::MAX_ENTRIES_DEF,
    parameter int SIZE_BITS   = wfba_pkg::SIZE_BITS_DEF
) (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                i_valid,
    output logic                                     o_stall,
    input  wire logic                                i_mode,
    input  wire logic [wfba_pkg::AMOUNT_BITS-1:0]    i_amount,
    output logic                                     o_valid,
    input  wire logic                                i_stall,
    output logic [1:0]                               o_status,
    output logic [wfba_pkg::IDX_OUT_BITS-1:0]        o_entry_index,
    output logic [wfba_pkg::ADDR_BITS-1:0]           o_start_address,
    output logic [wfba_pkg::OWNER_BITS-1:0]          o_request_number
);

    localparam int AB = wfba_pkg::ADDR_BITS;
    localparam int OB = wfba_pkg::OWNER_BITS;
    localparam int XB = wfba_pkg::IDX_OUT_BITS;
    localparam int IW = $clog2(MAX_ENTRIES);
    localparam int CW = $clog2(MAX_ENTRIES + 1);
    localparam int EW = SIZE_BITS + AB + 1 + OB;

    // Entry word layout: {size, start, taken, owner}
    localparam int OWN_LO   = 0;
    localparam int TAKEN_B  = OB;
    localparam int START_LO = OB + 1;
    localparam int SIZE_LO  = OB + 1 + AB;

    // Control state
    wfba_pkg::t_state  r_state, n_state;
    logic [CW-1:0]     r_count, n_count;
    logic [OB-1:0]     r_req, n_req;
    logic [AB-1:0]     r_next_addr, n_next_addr;
    logic [CW-1:0]     r_scan, n_scan;
    logic              r_rd_pend, n_rd_pend;
    logic              r_found, n_found;
    logic              r_out_valid, n_out_valid;

    // Working payload
    logic                  r_mode, n_mode;
    logic [SIZE_BITS-1:0]  r_amt, n_amt;
    logic [IW-1:0]         r_cidx, n_cidx;
    logic [IW-1:0]         r_best, n_best;
    logic [SIZE_BITS-1:0]  r_best_size, n_best_size;
    logic [AB-1:0]         r_best_start, n_best_start;
    logic [IW-1:0]         r_ptr, n_ptr;
    logic [IW-1:0]         r_wptr, n_wptr;
    wfba_pkg::t_status     r_res_status, n_res_status;
    logic [IW-1:0]         r_res_idx, n_res_idx;
    logic [AB-1:0]         r_res_addr, n_res_addr;
    logic [OB-1:0]         r_res_req, n_res_req;
    wfba_pkg::t_status     r_out_status, n_out_status;
    logic [XB-1:0]         r_out_idx, n_out_idx;
    logic [AB-1:0]         r_out_addr, n_out_addr;
    logic [OB-1:0]         r_out_req, n_out_req;

    // Memory port
    logic          w_we;
    logic [IW-1:0] w_waddr;
    logic [EW-1:0] w_wdata;
    logic          w_re;
    logic [IW-1:0] w_raddr;
    logic [EW-1:0] w_rdata;

    // Helpers
    localparam int AMOUNT_BITS_EXT_W = wfba_pkg::AMOUNT_BITS + SIZE_BITS;
    logic [AMOUNT_BITS_EXT_W-1:0] w_amt_ext;
    logic [SIZE_BITS-1:0]        w_amt;
    logic [SIZE_BITS-1:0]        w_rd_size;
    logic [AB-1:0]               w_rd_start;
    logic                        w_rd_taken;
    logic [SIZE_BITS-1:0]        w_rem;
    logic                        w_full;
    logic [CW-1:0]               w_last;
    logic [IW-1:0]               w_best_inc;
    logic [AB+SIZE_BITS-1:0]     w_load_sum;
    logic [AB+SIZE_BITS-1:0]     w_rem_sum;
    logic [IW+XB-1:0]            w_idx_ext;
    logic                        w_out_free;

    assign w_amt_ext  = {{SIZE_BITS{1'b0}}, i_amount};
    assign w_amt      = w_amt_ext[SIZE_BITS-1:0];
    assign w_rd_size  = w_rdata[SIZE_LO +: SIZE_BITS];
    assign w_rd_start = w_rdata[START_LO +: AB];
    assign w_rd_taken = w_rdata[TAKEN_B];
    assign w_rem      = r_best_size - r_amt;
    assign w_full     = (r_count >= CW'(MAX_ENTRIES));
    assign w_last     = r_count - CW'(1);
    assign w_best_inc = r_best + IW'(1);
    assign w_load_sum = {{SIZE_BITS{1'b0}}, r_next_addr} + {{AB{1'b0}}, r_amt};
    assign w_rem_sum  = {{SIZE_BITS{1'b0}}, r_best_start} + {{AB{1'b0}}, r_amt};
    assign w_idx_ext  = {{XB{1'b0}}, r_res_idx};
    assign w_out_free = !r_out_valid || !i_stall;

    wfba_mem #(
        .DEPTH (MAX_ENTRIES),
        .AW    (IW),
        .DW    (EW)
    ) u_mem (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_re    (w_re),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    // Sequencer: next state, memory access and result
    always_comb begin
        n_state      = r_state;
        n_count      = r_count;
        n_req        = r_req;
        n_next_addr  = r_next_addr;
        n_scan       = r_scan;
        n_rd_pend    = r_rd_pend;
        n_found      = r_found;
        n_out_valid  = r_out_valid;
        n_mode       = r_mode;
        n_amt        = r_amt;
        n_cidx       = r_cidx;
        n_best       = r_best;
        n_best_size  = r_best_size;
        n_best_start = r_best_start;
        n_ptr        = r_ptr;
        n_wptr       = r_wptr;
        n_res_status = r_res_status;
        n_res_idx    = r_res_idx;
        n_res_addr   = r_res_addr;
        n_res_req    = r_res_req;
        n_out_status = r_out_status;
        n_out_idx    = r_out_idx;
        n_out_addr   = r_out_addr;
        n_out_req    = r_out_req;
        w_we         = 1'b0;
        w_waddr      = '0;
        w_wdata      = '0;
        w_re         = 1'b0;
        w_raddr      = '0;

        // Drop the result once taken
        if (r_out_valid && !i_stall) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            wfba_pkg::S_IDLE: begin
                if (i_valid) begin
                    n_mode = i_mode;
                    n_amt  = w_amt;
                    if (!i_mode) begin
                        n_state = wfba_pkg::S_LOAD;
                    end else begin
                        if (r_req != {OB{1'b1}}) begin
                            n_req = r_req + OB'(1);
                        end
                        n_scan    = '0;
                        n_rd_pend = 1'b0;
                        n_found   = 1'b0;
                        n_best    = '0;
                        n_state   = wfba_pkg::S_SCAN;
                    end
                end
            end
            wfba_pkg::S_LOAD: begin
                if (w_full) begin
                    n_res_status = wfba_pkg::ST_FULL;
                    n_res_idx    = '0;
                    n_res_addr   = '0;
                end else begin
                    w_we         = 1'b1;
                    w_waddr      = r_count[IW-1:0];
                    w_wdata      = {r_amt, r_next_addr, 1'b0, {OB{1'b0}}};
                    n_count      = r_count + CW'(1);
                    n_next_addr  = w_load_sum[AB-1:0];
                    n_res_status = wfba_pkg::ST_DONE;
                    n_res_idx    = r_count[IW-1:0];
                    n_res_addr   = r_next_addr;
                end
                n_res_req = '0;
                n_state   = wfba_pkg::S_FINISH;
            end
            wfba_pkg::S_SCAN: begin
                // Issue one read a cycle, compare the entry returned
                if (r_scan < r_count) begin
                    w_re      = 1'b1;
                    w_raddr   = r_scan[IW-1:0];
                    n_scan    = r_scan + CW'(1);
                    n_cidx    = r_scan[IW-1:0];
                    n_rd_pend = 1'b1;
                end else begin
                    n_rd_pend = 1'b0;
                end
                if (r_rd_pend && !w_rd_taken && (w_rd_size >= r_amt)
                        && (!r_found || (w_rd_size > r_best_size))) begin
                    n_found      = 1'b1;
                    n_best       = r_cidx;
                    n_best_size  = w_rd_size;
                    n_best_start = w_rd_start;
                end
                if (!(r_scan < r_count) && !r_rd_pend) begin
                    n_state = wfba_pkg::S_DECIDE;
                end
            end
            wfba_pkg::S_DECIDE: begin
                n_res_req = r_req;
                if (!r_found) begin
                    n_res_status = wfba_pkg::ST_NOFIT;
                    n_res_idx    = '0;
                    n_res_addr   = '0;
                    n_state      = wfba_pkg::S_FINISH;
                end else if (w_rem != '0) begin
                    if (w_full) begin
                        n_res_status = wfba_pkg::ST_FULL;
                        n_res_idx    = '0;
                        n_res_addr   = '0;
                        n_state      = wfba_pkg::S_FINISH;
                    end else begin
                        n_ptr     = w_last[IW-1:0];
                        n_rd_pend = 1'b0;
                        n_state   = wfba_pkg::S_SHIFT;
                    end
                end else begin
                    n_state = wfba_pkg::S_WR_BEST;
                end
            end
            wfba_pkg::S_SHIFT: begin
                // Move entries above the chosen one up by one, top first
                if (r_rd_pend) begin
                    w_we    = 1'b1;
                    w_waddr = r_wptr;
                    w_wdata = w_rdata;
                end
                if (r_ptr > r_best) begin
                    w_re      = 1'b1;
                    w_raddr   = r_ptr;
                    n_wptr    = r_ptr + IW'(1);
                    n_ptr     = r_ptr - IW'(1);
                    n_rd_pend = 1'b1;
                end else begin
                    n_rd_pend = 1'b0;
                    if (!r_rd_pend) begin
                        n_state = wfba_pkg::S_WR_REM;
                    end
                end
            end
            wfba_pkg::S_WR_REM: begin
                w_we    = 1'b1;
                w_waddr = w_best_inc;
                w_wdata = {w_rem, w_rem_sum[AB-1:0], 1'b0, {OB{1'b0}}};
                n_count = r_count + CW'(1);
                n_state = wfba_pkg::S_WR_BEST;
            end
            wfba_pkg::S_WR_BEST: begin
                w_we         = 1'b1;
                w_waddr      = r_best;
                w_wdata      = {r_amt, r_best_start, 1'b1, r_req};
                n_res_status = wfba_pkg::ST_DONE;
                n_res_idx    = r_best;
                n_res_addr   = r_best_start;
                n_res_req    = r_req;
                n_state      = wfba_pkg::S_FINISH;
            end
            wfba_pkg::S_FINISH: begin
                // Hold until the output register is free
                if (w_out_free) begin
                    n_out_valid  = 1'b1;
                    n_out_status = r_res_status;
                    n_out_idx    = w_idx_ext[XB-1:0];
                    n_out_addr   = r_res_addr;
                    n_out_req    = r_res_req;
                    n_state      = wfba_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = wfba_pkg::S_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= wfba_pkg::S_IDLE;
            r_count     <= '0;
            r_req       <= '0;
            r_next_addr <= '0;
            r_scan      <= '0;
            r_rd_pend   <= 1'b0;
            r_found     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_req       <= n_req;
            r_next_addr <= n_next_addr;
            r_scan      <= n_scan;
            r_rd_pend   <= n_rd_pend;
            r_found     <= n_found;
            r_out_valid <= n_out_valid;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_mode       <= n_mode;
        r_amt        <= n_amt;
        r_cidx       <= n_cidx;
        r_best       <= n_best;
        r_best_size  <= n_best_size;
        r_best_start <= n_best_start;
        r_ptr        <= n_ptr;
        r_wptr       <= n_wptr;
        r_res_status <= n_res_status;
        r_res_idx    <= n_res_idx;
        r_res_addr   <= n_res_addr;
        r_res_req    <= n_res_req;
        r_out_status <= n_out_status;
        r_out_idx    <= n_out_idx;
        r_out_addr   <= n_out_addr;
        r_out_req    <= n_out_req;
    end

    assign o_stall          = (r_state != wfba_pkg::S_IDLE);
    assign o_valid          = r_out_valid;
    assign o_status         = r_out_status;
    assign o_entry_index    = r_out_idx;
    assign o_start_address  = r_out_addr;
    assign o_request_number = r_out_req;

    // Table never grows past its depth
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(MAX_ENTRIES))
        else $error("entry count above table depth");

    // Scan is read-only
    a_scan_no_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == wfba_pkg::S_SCAN) |-> !w_we)
        else $error("table write during scan");

    // Shift never overwrites the chosen entry or its remainder slot
    a_shift_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == wfba_pkg::S_SHIFT && w_we)
            |-> (w_waddr != r_best && w_waddr != w_best_inc))
        else $error("shift write hits chosen entry");

    // A chosen block always fits the request
    a_best_fits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == wfba_pkg::S_DECIDE && r_found) |-> (r_best_size >= r_amt))
        else $error("chosen block smaller than request");

    // Results appear only out of the finish state
    a_result_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_valid) |-> ($past(r_state) == wfba_pkg::S_FINISH))
        else $error("result raised outside finish");

endmodule

`default_nettype wire

@@ sim/tb.sv @@
`timescale 1ns / 1ps

module tb;

    localparam int TABLE_DEPTH   = wfba_pkg::MAX_ENTRIES_DEF;
    localparam int NUM_DIRECTED  = 20;
    localparam int RANDOM_ITEMS  = 1680;
    localparam int DRAIN_CYCLES  = 80;
    localparam int HOLD_AFTER    = 300;
    localparam int HOLD_CYCLES   = 400;
    localparam int MAX_PRINTED   = 40;

    localparam logic MODE_LOAD  = 1'b0;
    localparam logic MODE_ALLOC = 1'b1;

    typedef struct packed {
        wfba_pkg::t_status                 status;
        logic [wfba_pkg::IDX_OUT_BITS-1:0] idx;
        logic [wfba_pkg::ADDR_BITS-1:0]    addr;
        logic [wfba_pkg::OWNER_BITS-1:0]   reqno;
    } t_grant;

    typedef struct {
        logic                             mode;
        logic [wfba_pkg::AMOUNT_BITS-1:0] amount;
        bit                               typed;
        t_grant                           want;
    } t_stim_row;

    logic                              i_clk = 1'b0;
    logic                              i_rst_n;
    logic                              i_valid;
    logic                              o_stall;
    logic                              i_mode;
    logic [wfba_pkg::AMOUNT_BITS-1:0]  i_amount;
    logic                              o_valid;
    logic                              i_stall;
    logic [1:0]                        o_status;
    logic [wfba_pkg::IDX_OUT_BITS-1:0] o_entry_index;
    logic [wfba_pkg::ADDR_BITS-1:0]    o_start_address;
    logic [wfba_pkg::OWNER_BITS-1:0]   o_request_number;

    // Shadow copy of the block table
    logic [wfba_pkg::AMOUNT_BITS-1:0]  blk_size  [TABLE_DEPTH];
    logic [wfba_pkg::ADDR_BITS-1:0]    blk_start [TABLE_DEPTH];
    bit                                blk_taken [TABLE_DEPTH];
    logic [wfba_pkg::OWNER_BITS-1:0]   blk_owner [TABLE_DEPTH];
    int                                blk_count;
    logic [wfba_pkg::OWNER_BITS-1:0]   req_seq;
    logic [wfba_pkg::ADDR_BITS-1:0]    load_addr;

    t_grant    pending_grants [$];
    t_stim_row plan [NUM_DIRECTED];
    int        mismatch_count = 0;
    int        n_accepted = 0;
    bit        calm = 1'b0;
    bit        hold_done = 1'b0;

    worst_fit_block_allocator uut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (i_valid),
        .o_stall          (o_stall),
        .i_mode           (i_mode),
        .i_amount         (i_amount),
        .o_valid          (o_valid),
        .i_stall          (i_stall),
        .o_status         (o_status),
        .o_entry_index    (o_entry_index),
        .o_start_address  (o_start_address),
        .o_request_number (o_request_number)
    );

    always #10 i_clk = ~i_clk;

    // Worst-fit allocation on the shadow table; returns the expected grant
    function automatic t_grant predict_allocation(
            input logic mode, input logic [wfba_pkg::AMOUNT_BITS-1:0] amount);
        t_grant                           res;
        int                               best;
        bit                               found;
        logic [wfba_pkg::AMOUNT_BITS-1:0] rem;
        int                               j;
        res = '0;
        res.status = wfba_pkg::ST_DONE;
        if (mode == MODE_LOAD) begin
            if (blk_count >= TABLE_DEPTH) begin
                res.status = wfba_pkg::ST_FULL;
                return res;
            end
            blk_size[blk_count]  = amount;
            blk_start[blk_count] = load_addr;
            blk_taken[blk_count] = 1'b0;
            blk_owner[blk_count] = '0;
            res.idx  = blk_count[wfba_pkg::IDX_OUT_BITS-1:0];
            res.addr = load_addr;
            load_addr = load_addr + wfba_pkg::ADDR_BITS'(amount);
            blk_count++;
            return res;
        end
        // every request takes a number, saturating at the top
        if (req_seq != '1)
            req_seq = req_seq + 1'b1;
        res.reqno = req_seq;
        found = 1'b0;
        best = 0;
        for (j = 0; j < blk_count; j++) begin
            if (!blk_taken[j] && blk_size[j] >= amount &&
                (!found || blk_size[j] > blk_size[best])) begin
                best = j;
                found = 1'b1;
            end
        end
        if (!found) begin
            res.status = wfba_pkg::ST_NOFIT;
            return res;
        end
        rem = blk_size[best] - amount;
        if (rem != '0) begin
            // split needs a free slot; refuse the whole request otherwise
            if (blk_count >= TABLE_DEPTH) begin
                res.status = wfba_pkg::ST_FULL;
                return res;
            end
            for (j = blk_count; j > best + 1; j--) begin
                blk_size[j]  = blk_size[j-1];
                blk_start[j] = blk_start[j-1];
                blk_taken[j] = blk_taken[j-1];
                blk_owner[j] = blk_owner[j-1];
            end
            blk_size[best+1]  = rem;
            blk_start[best+1] = blk_start[best] + wfba_pkg::ADDR_BITS'(amount);
            blk_taken[best+1] = 1'b0;
            blk_owner[best+1] = '0;
            blk_count++;
        end
        blk_taken[best] = 1'b1;
        blk_owner[best] = req_seq;
        blk_size[best]  = amount;
        res.idx  = best[wfba_pkg::IDX_OUT_BITS-1:0];
        res.addr = blk_start[best];
        return res;
    endfunction

    // Mostly short gaps, a few long ones, none during calm stretches
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (calm || r < 45)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    task automatic report_mismatch(input string msg);
        if (mismatch_count < MAX_PRINTED)
            $display("[%0t] mismatch: %s", $time, msg);
        mismatch_count++;
    endtask

    // Offer one request and hold it until accepted; called at a falling edge
    task automatic send_request(input logic mode,
                                input logic [wfba_pkg::AMOUNT_BITS-1:0] amount,
                                input bit typed, input t_grant want);
        int     gap;
        t_grant exp_grant;
        gap = pick_gap();
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_valid  <= 1'b1;
        i_mode   <= mode;
        i_amount <= amount;
        do @(posedge i_clk); while (o_stall);
        exp_grant = predict_allocation(mode, amount);
        if (typed)
            exp_grant = want;
        pending_grants.push_back(exp_grant);
        n_accepted++;
        @(negedge i_clk);
    endtask

    // Compare each delivered result against the oldest expectation
    always @(posedge i_clk) begin
        t_grant want;
        if (i_rst_n && o_valid && !i_stall) begin
            if (pending_grants.size() == 0) begin
                report_mismatch("result with nothing outstanding");
            end else begin
                want = pending_grants.pop_front();
                if (o_status !== want.status)
                    report_mismatch($sformatf("status got %0d expected %0d",
                                              o_status, want.status));
                if (o_entry_index !== want.idx)
                    report_mismatch($sformatf("entry_index got %0d expected %0d",
                                              o_entry_index, want.idx));
                if (o_start_address !== want.addr)
                    report_mismatch($sformatf("start_address got %0d expected %0d",
                                              o_start_address, want.addr));
                if (o_request_number !== want.reqno)
                    report_mismatch($sformatf("request_number got %0d expected %0d",
                                              o_request_number, want.reqno));
            end
        end
    end

    // Receiver: random stalls plus one long hold-off to back the block up
    initial begin
        int stall_left;
        stall_left = 0;
        i_stall = 1'b0;
        forever begin
            @(negedge i_clk);
            if (!hold_done && n_accepted >= HOLD_AFTER) begin
                hold_done = 1'b1;
                i_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(negedge i_clk);
                i_stall <= 1'b0;
            end else begin
                if (stall_left > 0)
                    stall_left--;
                else if (!calm && $urandom_range(0, 99) < 35)
                    stall_left = pick_gap();
                i_stall <= (stall_left > 0);
            end
        end
    end

    // Directed table, then random traffic, then drain
    initial begin
        int                               k;
        int                               j;
        int                               free_n;
        int                               free_idx [TABLE_DEPTH];
        int                               pick;
        int                               shape;
        logic                             m;
        logic [wfba_pkg::AMOUNT_BITS-1:0] amt;
        logic [wfba_pkg::AMOUNT_BITS-1:0] base;

        i_rst_n  = 1'b0;
        i_valid  = 1'b0;
        i_mode   = MODE_LOAD;
        i_amount = '0;
        blk_count = 0;
        req_seq   = '0;
        load_addr = '0;

        plan = '{
            '{MODE_ALLOC, 16'd5,    1'b1, '{wfba_pkg::ST_NOFIT, 5'd0, 24'd0,   16'd1}},
            '{MODE_LOAD,  16'd100,  1'b1, '{wfba_pkg::ST_DONE,  5'd0, 24'd0,   16'd0}},
            '{MODE_LOAD,  16'd100,  1'b1, '{wfba_pkg::ST_DONE,  5'd1, 24'd100, 16'd0}},
            '{MODE_LOAD,  16'd0,    1'b1, '{wfba_pkg::ST_DONE,  5'd2, 24'd200, 16'd0}},
            '{MODE_LOAD,  16'hFFFF, 1'b1, '{wfba_pkg::ST_DONE,  5'd3, 24'd200, 16'd0}},
            '{MODE_ALLOC, 16'd0,    1'b0, '0},
            '{MODE_ALLOC, 16'hFFFF, 1'b0, '0},
            '{MODE_ALLOC, 16'd100,  1'b0, '0},
            '{MODE_ALLOC, 16'd60,   1'b0, '0},
            '{MODE_ALLOC, 16'hFFFF, 1'b1, '{wfba_pkg::ST_NOFIT, 5'd0, 24'd0,   16'd6}},
            '{MODE_LOAD,  16'h5555, 1'b0, '0},
            '{MODE_LOAD,  16'hAAAA, 1'b0, '0},
            '{MODE_ALLOC, 16'h5555, 1'b0, '0},
            '{MODE_ALLOC, 16'd1,    1'b0, '0},
            '{MODE_ALLOC, 16'd0,    1'b0, '0},
            '{MODE_LOAD,  16'd1,    1'b0, '0},
            '{MODE_ALLOC, 16'd1,    1'b0, '0},
            '{MODE_LOAD,  16'hFFFF, 1'b0, '0},
            '{MODE_ALLOC, 16'h8000, 1'b0, '0},
            '{MODE_ALLOC, 16'hFFFF, 1'b0, '0}
        };

        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        for (k = 0; k < NUM_DIRECTED; k++)
            send_request(plan[k].mode, plan[k].amount, plan[k].typed, plan[k].want);

        // Random traffic: requests mostly aimed at the sizes of free blocks
        for (k = 0; k < RANDOM_ITEMS; k++) begin
            if (k % 64 == 0)
                calm = ($urandom_range(0, 3) == 0);
            free_n = 0;
            for (j = 0; j < blk_count; j++) begin
                if (!blk_taken[j]) begin
                    free_idx[free_n] = j;
                    free_n++;
                end
            end
            pick = $urandom_range(0, 99);
            if (pick < 25) begin
                m = MODE_LOAD;
                if ($urandom_range(0, 3) == 0)
                    amt = wfba_pkg::AMOUNT_BITS'($urandom);
                else
                    amt = wfba_pkg::AMOUNT_BITS'($urandom_range(0, 300));
            end else begin
                m = MODE_ALLOC;
                if (free_n > 0)
                    base = blk_size[free_idx[$urandom_range(0, free_n - 1)]];
                else
                    base = wfba_pkg::AMOUNT_BITS'($urandom);
                shape = $urandom_range(0, 99);
                if (shape < 35)
                    amt = base;
                else if (shape < 65)
                    amt = base - wfba_pkg::AMOUNT_BITS'($urandom_range(0, base));
                else if (shape < 75)
                    amt = base + 1'b1;
                else if (shape < 95)
                    amt = wfba_pkg::AMOUNT_BITS'($urandom);
                else
                    amt = '0;
            end
            send_request(m, amt, 1'b0, '0);
        end
        i_valid <= 1'b0;

        // Drain outstanding results, then watch for strays
        while (pending_grants.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (mismatch_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

    // Watchdog
    initial begin
        #40_000_000;
        $display("CHECKS FAILED");
        $finish;
    end

endmodule
